>>> rtl/core/oaht_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Open address hash table package
// Shared types, codes and hash constants for the hash table block.
// ----------------------------------------------------------------------------
package oaht_pkg;

   localparam int SLOTS_DEFAULT = 1024;
   localparam int COUNT_W = 11;
   localparam int FILL_W = 11;
   localparam int PROBE_W = 12;
   localparam int CSR_W = 12;
   localparam int FILL_RESET = 717;
   localparam int PROBE_RESET = 1037;

   localparam logic [0:0] CSR_FILL_LIMIT = 1'd0;
   localparam logic [0:0] CSR_PROBE_LIMIT = 1'd1;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;
   localparam logic [1:0] KIND_LOOKUP = 2'd2;

   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_UPDATED = 3'd1;
   localparam logic [2:0] ST_REMOVED = 3'd2;
   localparam logic [2:0] ST_FOUND = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;
   localparam logic [2:0] ST_FULL = 3'd5;
   localparam logic [2:0] ST_ZERO_VALUE = 3'd6;

   localparam logic [1:0] MARK_UNUSED = 2'd0;
   localparam logic [1:0] MARK_LIVE = 2'd1;
   localparam logic [1:0] MARK_TOMB = 2'd2;

   localparam logic [63:0] MIX_ADD = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_MUL_B = 64'h94d049bb133111eb;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] key;
      logic [63:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [63:0]        read_value;
      logic [COUNT_W-1:0] live_entries;
   } rsp_type;

   typedef struct packed {
      req_type     req;
      logic [63:0] hash;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

>>> rtl/core/oaht_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module oaht_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

>>> rtl/core/oaht_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Hash table front end
// Accepts a request beat and hashes its key with a shared 32-bit multiplier.
// ----------------------------------------------------------------------------
module oaht_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      accept,
   input  wire oaht_pkg::req_type         req_item,
   input  wire oaht_pkg::queue_status_type q_status,
   output logic                           front_busy,
   output logic                           push,
   output oaht_pkg::job_type              push_job
);

   typedef enum logic [2:0] {
      F_IDLE, F_MIX1, F_MUL, F_MIX2, F_MIX3, F_PUSH
   } front_state_type;

   front_state_type    state_ff;
   oaht_pkg::req_type  req_ff;
   logic [63:0]        h_ff;
   logic [63:0]        acc_ff;
   logic [63:0]        mprod_ff;
   logic [1:0]         step_ff;
   logic               second_ff;
   logic [31:0]        op_a;
   logic [31:0]        op_b;
   logic [63:0]        mul_const;

   always_comb begin
      mul_const = second_ff ? oaht_pkg::MIX_MUL_B : oaht_pkg::MIX_MUL_A;
      unique case (step_ff)
         2'd1: begin
            op_a = h_ff[63:32];
            op_b = mul_const[31:0];
         end
         2'd2: begin
            op_a = h_ff[31:0];
            op_b = mul_const[63:32];
         end
         default: begin
            op_a = h_ff[31:0];
            op_b = mul_const[31:0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mprod_ff <= op_a * op_b;
      if (reset) begin
         state_ff <= F_IDLE;
         step_ff <= 2'd0;
         second_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (accept) begin
                  req_ff <= req_item;
                  h_ff <= req_item.key + oaht_pkg::MIX_ADD;
                  state_ff <= F_MIX1;
               end
            end
            F_MIX1: begin
               h_ff <= h_ff ^ (h_ff >> 30);
               second_ff <= 1'b0;
               step_ff <= 2'd0;
               state_ff <= F_MUL;
            end
            F_MUL: begin
               step_ff <= step_ff + 2'd1;
               unique case (step_ff)
                  2'd0: ;
                  2'd1: acc_ff <= mprod_ff;
                  2'd2: acc_ff[63:32] <= acc_ff[63:32] + mprod_ff[31:0];
                  default: begin
                     h_ff <= {acc_ff[63:32] + mprod_ff[31:0], acc_ff[31:0]};
                     state_ff <= second_ff ? F_MIX3 : F_MIX2;
                  end
               endcase
            end
            F_MIX2: begin
               h_ff <= h_ff ^ (h_ff >> 27);
               second_ff <= 1'b1;
               step_ff <= 2'd0;
               state_ff <= F_MUL;
            end
            F_MIX3: begin
               h_ff <= h_ff ^ (h_ff >> 31);
               state_ff <= F_PUSH;
            end
            default: begin
               if (!q_status.full) begin
                  state_ff <= F_IDLE;
               end
            end
         endcase
      end
   end

   assign front_busy = (state_ff != F_IDLE);
   assign push = (state_ff == F_PUSH) && !q_status.full;
   assign push_job = '{req: req_ff, hash: h_ff};

endmodule
`default_nettype wire

>>> rtl/core/oaht_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Hash table job queue
// Two-entry queue of hashed requests between the front and back ends.
// ----------------------------------------------------------------------------
module oaht_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire oaht_pkg::job_type push_job,
   input  wire logic              pop,
   output oaht_pkg::job_type      head_job,
   output oaht_pkg::queue_status_type q_status
);

   oaht_pkg::job_type entry_ff [2];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   assign head_job = entry_ff[rd_ptr_ff];
   assign q_status = '{full: (count_ff == 2'd2), empty: (count_ff == 2'd0)};

endmodule
`default_nettype wire

>>> rtl/core/oaht_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Hash table back end
// Probes the slot memories for each queued job, updates them and answers.
// ----------------------------------------------------------------------------
module oaht_back #(
   parameter int SLOTS = oaht_pkg::SLOTS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [oaht_pkg::FILL_W-1:0]  fill_limit,
   input  wire logic [oaht_pkg::PROBE_W-1:0] probe_limit,
   input  wire oaht_pkg::job_type            head_job,
   input  wire oaht_pkg::queue_status_type   q_status,
   output logic                              pop,
   output logic                              clearing,
   output logic                              rsp_valid,
   output oaht_pkg::rsp_type                 rsp_item
);

   localparam int IW = $clog2(SLOTS);
   localparam int CW = oaht_pkg::COUNT_W;

   typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_READ, B_EVAL} back_state_type;

   back_state_type                 state_ff;
   logic [IW-1:0]                  clr_ff;
   logic [1:0]                     kind_ff;
   logic [63:0]                    key_ff;
   logic [63:0]                    value_ff;
   logic [63:0]                    pert_ff;
   logic [IW-1:0]                  idx_ff;
   logic [oaht_pkg::PROBE_W-1:0]   n_ff;
   logic                           free_valid_ff;
   logic [IW-1:0]                  free_ff;
   logic [CW-1:0]                  count_ff;

   logic [63:0]                    key_rd;
   logic [63:0]                    val_rd;
   logic [1:0]                     mark_rd;

   logic [oaht_pkg::PROBE_W-1:0]   limit;
   logic [63:0]                    pert_in;
   logic [IW-1:0]                  idx_in;
   logic                           live;
   logic                           match;
   logic                           hit_empty;
   logic                           last;
   logic                           done;
   logic [IW-1:0]                  slot;
   logic                           room;
   logic                           key_we;
   logic                           val_we;
   logic                           mark_we;
   logic [IW-1:0]                  val_addr;
   logic [IW-1:0]                  mark_addr;
   logic [1:0]                     mark_data;
   logic [2:0]                     status_in;
   logic [63:0]                    rd_in;
   logic [CW-1:0]                  count_in;

   always_comb begin
      limit = (probe_limit == '0) ? oaht_pkg::PROBE_W'(1) : probe_limit;
      pert_in = pert_ff >> 5;
      idx_in = (idx_ff << 2) + idx_ff + pert_in[IW-1:0] + IW'(1);
      live = (mark_rd == oaht_pkg::MARK_LIVE);
      match = live && (key_rd == key_ff);
      hit_empty = (mark_rd == oaht_pkg::MARK_UNUSED);
      last = ({1'b0, n_ff} + 13'd1) >= {1'b0, limit};
      done = match || hit_empty || last;
      slot = free_valid_ff ? free_ff : idx_ff;
      room = (count_ff < fill_limit) && (32'(count_ff) < 32'(SLOTS));
      key_we = 1'b0;
      val_we = 1'b0;
      mark_we = 1'b0;
      val_addr = slot;
      mark_addr = slot;
      mark_data = oaht_pkg::MARK_LIVE;
      status_in = oaht_pkg::ST_NOT_FOUND;
      rd_in = '0;
      count_in = count_ff;
      if (state_ff == B_CLEAR) begin
         mark_we = 1'b1;
         mark_addr = clr_ff;
         mark_data = oaht_pkg::MARK_UNUSED;
      end else if (state_ff == B_EVAL && done) begin
         priority if (kind_ff == oaht_pkg::KIND_INSERT) begin
            if (match) begin
               val_we = 1'b1;
               val_addr = idx_ff;
               status_in = oaht_pkg::ST_UPDATED;
            end else if (hit_empty && room) begin
               key_we = 1'b1;
               val_we = 1'b1;
               mark_we = 1'b1;
               count_in = count_ff + CW'(1);
               status_in = oaht_pkg::ST_INSERTED;
            end else begin
               status_in = oaht_pkg::ST_FULL;
            end
         end else if (kind_ff == oaht_pkg::KIND_REMOVE) begin
            if (match) begin
               mark_we = 1'b1;
               mark_addr = idx_ff;
               mark_data = oaht_pkg::MARK_TOMB;
               status_in = oaht_pkg::ST_REMOVED;
               if (count_ff != '0) begin
                  count_in = count_ff - CW'(1);
               end
            end
         end else begin
            if (match) begin
               status_in = oaht_pkg::ST_FOUND;
               rd_in = val_rd;
            end
         end
      end
   end

   assign pop = (state_ff == B_IDLE) && !q_status.empty;
   assign clearing = (state_ff == B_CLEAR);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_CLEAR;
         clr_ff <= '0;
         count_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         unique case (state_ff)
            B_CLEAR: begin
               clr_ff <= clr_ff + IW'(1);
               if (clr_ff == IW'(SLOTS - 1)) begin
                  state_ff <= B_IDLE;
               end
            end
            B_IDLE: begin
               if (!q_status.empty) begin
                  kind_ff <= head_job.req.kind;
                  key_ff <= head_job.req.key;
                  value_ff <= head_job.req.value;
                  pert_ff <= head_job.hash;
                  idx_ff <= head_job.hash[IW-1:0];
                  n_ff <= '0;
                  free_valid_ff <= 1'b0;
                  if (head_job.req.kind == oaht_pkg::KIND_INSERT &&
                      head_job.req.value == '0) begin
                     rsp_valid <= 1'b1;
                     rsp_item <= '{status: oaht_pkg::ST_ZERO_VALUE, read_value: '0,
                                   live_entries: count_ff};
                  end else if (head_job.req.kind != oaht_pkg::KIND_INSERT &&
                               head_job.req.kind != oaht_pkg::KIND_REMOVE &&
                               head_job.req.kind != oaht_pkg::KIND_LOOKUP) begin
                     rsp_valid <= 1'b1;
                     rsp_item <= '{status: oaht_pkg::ST_NOT_FOUND, read_value: '0,
                                   live_entries: count_ff};
                  end else begin
                     state_ff <= B_READ;
                  end
               end
            end
            B_READ: begin
               state_ff <= B_EVAL;
            end
            default: begin
               if (done) begin
                  count_ff <= count_in;
                  rsp_valid <= 1'b1;
                  rsp_item <= '{status: status_in, read_value: rd_in,
                                live_entries: count_in};
                  state_ff <= B_IDLE;
               end else begin
                  if (!live && !free_valid_ff) begin
                     free_valid_ff <= 1'b1;
                     free_ff <= idx_ff;
                  end
                  n_ff <= n_ff + oaht_pkg::PROBE_W'(1);
                  pert_ff <= pert_in;
                  idx_ff <= idx_in;
                  state_ff <= B_READ;
               end
            end
         endcase
      end
   end

   oaht_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_keys (
      .clock(clock), .wr_en(key_we), .wr_addr(slot), .wr_data(key_ff),
      .rd_addr(idx_ff), .rd_data(key_rd)
   );

   oaht_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_values (
      .clock(clock), .wr_en(val_we), .wr_addr(val_addr), .wr_data(value_ff),
      .rd_addr(idx_ff), .rd_data(val_rd)
   );

   oaht_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_marks (
      .clock(clock), .wr_en(mark_we), .wr_addr(mark_addr), .wr_data(mark_data),
      .rd_addr(idx_ff), .rd_data(mark_rd)
   );

endmodule
`default_nettype wire

>>> rtl/core/open_address_hash_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Open address hash table
// Insert, remove and lookup of 64-bit keys with perturbed probing.
// ----------------------------------------------------------------------------
// Hashing in the front end uses the shared 32-bit multiplier; the back end then reads
// the slot memories and evaluates each probed slot in turn before it answers.
// The front end takes no new request while it hashes, and the back end takes no new
// job from the queue until it has answered the last one; the queue lets them overlap.
// Reset clears the slot marks in a pass over every slot with busy high.
// Results are strobed for one cycle; the receiver cannot stall them.
module open_address_hash_table #(
   parameter int SLOTS = oaht_pkg::SLOTS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire oaht_pkg::req_type         req_item,
   output logic                           rsp_valid,
   output oaht_pkg::rsp_type              rsp_item,
   input  wire logic                      csr_we,
   input  wire logic [0:0]                csr_index,
   input  wire logic [oaht_pkg::CSR_W-1:0] csr_data
);

   logic [oaht_pkg::FILL_W-1:0]  fill_limit_ff;
   logic [oaht_pkg::PROBE_W-1:0] probe_limit_ff;
   logic                         front_busy;
   logic                         clearing;
   logic                         push;
   logic                         pop;
   oaht_pkg::job_type            push_job;
   oaht_pkg::job_type            head_job;
   oaht_pkg::queue_status_type   q_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_limit_ff <= oaht_pkg::FILL_W'(oaht_pkg::FILL_RESET);
         probe_limit_ff <= oaht_pkg::PROBE_W'(oaht_pkg::PROBE_RESET);
      end else if (csr_we) begin
         unique case (csr_index)
            oaht_pkg::CSR_FILL_LIMIT: fill_limit_ff <= csr_data[oaht_pkg::FILL_W-1:0];
            default: probe_limit_ff <= csr_data;
         endcase
      end
   end

   assign busy = front_busy || clearing;

   oaht_front u_front (
      .clock(clock), .reset(reset), .accept(start && !busy), .req_item(req_item),
      .q_status(q_status), .front_busy(front_busy), .push(push), .push_job(push_job)
   );

   oaht_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_job(push_job), .pop(pop),
      .head_job(head_job), .q_status(q_status)
   );

   oaht_back #(.SLOTS(SLOTS)) u_back (
      .clock(clock), .reset(reset), .fill_limit(fill_limit_ff),
      .probe_limit(probe_limit_ff), .head_job(head_job), .q_status(q_status),
      .pop(pop), .clearing(clearing), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   a_reset_clears : assert property (@(posedge clock) reset |=> busy)
      else $error("busy low after reset");

   a_no_rsp_in_clear : assert property (@(posedge clock) disable iff (reset)
      !(clearing && rsp_valid))
      else $error("result during clearing pass");

   a_read_value_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status != oaht_pkg::ST_FOUND) |-> rsp_item.read_value == '0)
      else $error("read value set without a hit");

   a_live_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_item.live_entries) <= 32'(SLOTS))
      else $error("live entries beyond capacity");

endmodule
`default_nettype wire
